>>> hdl/bgr_pkg.sv
// Shared types, constants and helper functions of the glyph row renderer.
package bgr_pkg;

  localparam int CODE_BITS = 16;
  localparam int CODE_SPACE = 1 << CODE_BITS;
  localparam int GLYPH_BITS = 12;
  localparam int ROW_BITS = 5;
  localparam int GLYPH_ADDR_BITS = GLYPH_BITS + ROW_BITS;
  localparam int GLYPH_WORDS = 1 << GLYPH_ADDR_BITS;
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int MAX_GLYPH_WIDTH = 32;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [1:0] CMD_MAP  = 2'd0;
  localparam logic [1:0] CMD_ROW  = 2'd1;
  localparam logic [1:0] CMD_DRAW = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_CLIP_LEFT    = 3'd2;
  localparam logic [2:0] REG_CLIP_RIGHT   = 3'd3;
  localparam logic [2:0] REG_CLIP_TOP     = 3'd4;
  localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd5;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd6;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd7;

  localparam logic [20:0] COMB_A_LO = 21'h00300;
  localparam logic [20:0] COMB_A_HI = 21'h0036F;
  localparam logic [20:0] COMB_B_LO = 21'h0FE20;
  localparam logic [20:0] COMB_B_HI = 21'h0FE2F;
  localparam logic [CODE_BITS-1:0] FALLBACK_CP = 16'hFFFD;

  typedef struct packed {
    logic signed [14:0] origin_x;
    logic signed [14:0] origin_y;
    logic [11:0]        clip_left;
    logic [11:0]        clip_right;
    logic [11:0]        clip_top;
    logic [11:0]        clip_bottom;
    logic [5:0]         glyph_width;
    logic [5:0]         glyph_height;
  } cfg_t;

  typedef struct packed {
    logic                   is_draw;
    logic [GLYPH_BITS-1:0]  glyph;
    logic [ROW_BITS-1:0]    row;
    logic [31:0]            bits;
    logic signed [17:0]     x0;
    logic [15:0]            pen_after;
    logic                   last;
  } q_entry_t;

  typedef struct packed {
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic               row_valid;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [31:0]        row_mask;
    logic [15:0]        pen_after;
    logic               last;
  } r_entry_t;

  function automatic logic [5:0] sat_dim(input logic [5:0] v, input logic [5:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [5:0] clamp_dim(input logic signed [18:0] v, input logic [5:0] hi);
    if (v < 19'sd0) begin
      return 6'd0;
    end
    if (v > $signed({13'b0, hi})) begin
      return hi;
    end
    return v[5:0];
  endfunction

  function automatic logic [31:0] low_bits(input logic [5:0] n);
    logic [32:0] t;
    t = (33'd1 << n) - 33'd1;
    return t[31:0];
  endfunction

endpackage

>>> hdl/bgr_front.sv
// Front end: takes commands, owns the code map and the pen, classifies work for the back end.
module bgr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           command,
  input  logic [20:0]          code_point,
  input  logic [11:0]          glyph_index,
  input  logic                 map_valid,
  input  logic [4:0]           glyph_row,
  input  logic [31:0]          row_bits,
  input  logic                 last_char,
  input  bgr_pkg::cfg_t        cfg,
  input  bgr_pkg::q_status_t   q_status,
  output logic                 q_push,
  output bgr_pkg::q_entry_t    q_data
);

  logic [12:0] code_map [0:bgr_pkg::CODE_SPACE-1];
  logic [12:0] map_rd;
  logic        clearing;
  logic [bgr_pkg::CODE_BITS-1:0] clr_addr;
  logic        fb_valid;
  logic [bgr_pkg::GLYPH_BITS-1:0] fb_glyph;
  logic [15:0] pen;

  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [20:0] s1_cp;
  logic [11:0] s1_gi;
  logic [4:0]  s1_gr;
  logic [31:0] s1_bits;
  logic        s1_last;

  logic        accept;
  logic        map_we;
  logic        in_code_space;
  logic        hit;
  logic [11:0] glyph;
  logic [5:0]  gw;
  logic        combining;
  logic [5:0]  adv;
  logic [16:0] pen_sum;
  logic [15:0] pen_next;
  logic [15:0] pen_after;
  logic signed [17:0] x0;
  logic        s1_draw;

  assign full = clearing
              | (({1'b0, q_status.count} + {3'b0, s1_valid}) >= 4'(bgr_pkg::Q_DEPTH));
  assign accept = push & ~full;
  assign map_we = accept && (command == bgr_pkg::CMD_MAP)
               && (code_point[20:bgr_pkg::CODE_BITS] == '0);

  always_ff @(posedge clk) begin
    if (clearing) begin
      code_map[clr_addr] <= '0;
    end else if (map_we) begin
      code_map[code_point[bgr_pkg::CODE_BITS-1:0]] <= {map_valid, glyph_index};
    end
    map_rd <= code_map[code_point[bgr_pkg::CODE_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_valid <= 1'b0;
    end else if (map_we && (code_point[bgr_pkg::CODE_BITS-1:0] == bgr_pkg::FALLBACK_CP)) begin
      fb_valid <= map_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we && (code_point[bgr_pkg::CODE_BITS-1:0] == bgr_pkg::FALLBACK_CP)) begin
      fb_glyph <= glyph_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= command;
      s1_cp   <= code_point;
      s1_gi   <= glyph_index;
      s1_gr   <= glyph_row;
      s1_bits <= row_bits;
      s1_last <= last_char;
    end
  end

  assign in_code_space = (s1_cp[20:bgr_pkg::CODE_BITS] == '0);
  assign hit = in_code_space & map_rd[12];
  assign glyph = hit ? map_rd[11:0] : (fb_valid ? fb_glyph : '0);
  assign gw = bgr_pkg::sat_dim(cfg.glyph_width, 6'(bgr_pkg::MAX_GLYPH_WIDTH));
  assign combining = ((s1_cp >= bgr_pkg::COMB_A_LO) && (s1_cp <= bgr_pkg::COMB_A_HI))
                  || ((s1_cp >= bgr_pkg::COMB_B_LO) && (s1_cp <= bgr_pkg::COMB_B_HI));
  assign adv = (s1_last || !combining) ? gw : 6'd0;
  assign pen_sum = {1'b0, pen} + {11'b0, adv};
  assign pen_after = pen_sum[16] ? 16'hFFFF : pen_sum[15:0];
  assign pen_next = s1_last ? 16'd0 : pen_after;
  assign x0 = $signed({{3{cfg.origin_x[14]}}, cfg.origin_x}) + $signed({2'b0, pen});
  assign s1_draw = s1_valid && (s1_cmd == bgr_pkg::CMD_DRAW);

  always_ff @(posedge clk) begin
    if (rst) begin
      pen <= '0;
    end else if (s1_draw) begin
      pen <= pen_next;
    end
  end

  assign q_push = s1_valid && ((s1_cmd == bgr_pkg::CMD_ROW) || (s1_cmd == bgr_pkg::CMD_DRAW));

  always_comb begin
    q_data.is_draw   = (s1_cmd == bgr_pkg::CMD_DRAW);
    q_data.glyph     = q_data.is_draw ? glyph : s1_gi;
    q_data.row       = s1_gr;
    q_data.bits      = s1_bits;
    q_data.x0        = x0;
    q_data.pen_after = pen_after;
    q_data.last      = s1_last;
  end

endmodule

>>> hdl/bgr_queue.sv
// Short work queue between the front end and the back end.
module bgr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  bgr_pkg::q_entry_t   wr_data,
  input  logic                rd,
  output bgr_pkg::q_entry_t   rd_data,
  output bgr_pkg::q_status_t  status
);

  bgr_pkg::q_entry_t slots [0:bgr_pkg::Q_DEPTH-1];
  logic [bgr_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [bgr_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [bgr_pkg::Q_CNT_W-1:0] count;
  logic do_rd;

  assign do_rd = rd && (count != '0);
  assign rd_data = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {2'b0, wr} - {2'b0, do_rd};
    end
  end

endmodule

>>> hdl/bgr_back.sv
// Back end: glyph row store, row sequencer with clipping, and the result queue.
module bgr_back (
  input  logic               clk,
  input  logic               rst,
  input  bgr_pkg::q_entry_t  q_head,
  input  logic               q_empty,
  output logic               q_pop,
  input  bgr_pkg::cfg_t      cfg,
  input  logic               pop,
  output logic               empty,
  output logic               row_valid,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic [31:0]        row_mask,
  output logic [15:0]        pen_after,
  output logic               last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_ROWS  = 2'd2;

  logic [31:0] glyph_mem [0:bgr_pkg::GLYPH_WORDS-1];
  logic [31:0] rd_data;

  logic [1:0]  state;
  logic        inflight;
  logic [bgr_pkg::GLYPH_BITS-1:0] d_glyph;
  logic signed [17:0] d_x0;
  logic [15:0] d_pen;
  logic [31:0] colmask;
  logic [5:0]  gy;
  logic [5:0]  gy_end;
  logic signed [15:0] row_py;
  logic        row_last;

  bgr_pkg::r_entry_t oq [0:bgr_pkg::Q_DEPTH-1];
  logic [bgr_pkg::Q_PTR_W-1:0] oq_wr;
  logic [bgr_pkg::Q_PTR_W-1:0] oq_rd;
  logic [bgr_pkg::Q_CNT_W-1:0] oq_count;

  logic [5:0]  gw;
  logic [5:0]  gh;
  logic [5:0]  gy0;
  logic [5:0]  gy1;
  logic [5:0]  gx0;
  logic [5:0]  gx1;
  logic signed [18:0] dy_top;
  logic signed [18:0] dy_bot;
  logic signed [18:0] dx_left;
  logic signed [18:0] dx_right;
  logic        clipped;
  logic        room;
  logic        mem_we;
  logic        issue;
  logic        push_clip;
  logic        oq_push;
  logic        oq_pop;
  logic [5:0]  gy_inc;
  logic signed [15:0] oy16;
  logic signed [15:0] px_sat;
  bgr_pkg::r_entry_t oq_in;
  bgr_pkg::r_entry_t oq_out;

  assign gw = bgr_pkg::sat_dim(cfg.glyph_width, 6'(bgr_pkg::MAX_GLYPH_WIDTH));
  assign gh = bgr_pkg::sat_dim(cfg.glyph_height, 6'(bgr_pkg::MAX_GLYPH_HEIGHT));
  assign dy_top = $signed({7'b0, cfg.clip_top}) - $signed({{4{cfg.origin_y[14]}}, cfg.origin_y});
  assign dy_bot = $signed({7'b0, cfg.clip_bottom})
                - $signed({{4{cfg.origin_y[14]}}, cfg.origin_y});
  assign dx_left = $signed({7'b0, cfg.clip_left}) - $signed({d_x0[17], d_x0});
  assign dx_right = $signed({7'b0, cfg.clip_right}) - $signed({d_x0[17], d_x0});
  assign gy0 = bgr_pkg::clamp_dim(dy_top, gh);
  assign gy1 = bgr_pkg::clamp_dim(dy_bot, gh);
  assign gx0 = bgr_pkg::clamp_dim(dx_left, gw);
  assign gx1 = bgr_pkg::clamp_dim(dx_right, gw);
  assign clipped = (gy0 >= gy1) || (gx0 >= gx1);

  assign oy16 = {cfg.origin_y[14], cfg.origin_y};
  assign gy_inc = gy + 6'd1;

  always_comb begin
    if (d_x0 > 18'sd32767) begin
      px_sat = 16'sh7FFF;
    end else if (d_x0 < -18'sd32768) begin
      px_sat = 16'sh8000;
    end else begin
      px_sat = d_x0[15:0];
    end
  end

  assign room = ({1'b0, oq_count} + {3'b0, inflight}) < 4'(bgr_pkg::Q_DEPTH);
  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign mem_we = q_pop && !q_head.is_draw;
  assign issue = (state == ST_ROWS) && room;
  assign push_clip = (state == ST_SETUP) && clipped && room;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[{q_head.glyph, q_head.row}] <= q_head.bits;
    end
    if (issue) begin
      rd_data <= glyph_mem[{d_glyph, gy[bgr_pkg::ROW_BITS-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      inflight <= 1'b0;
    end else begin
      inflight <= issue;
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_head.is_draw) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (!clipped) begin
            state <= ST_ROWS;
          end else if (room) begin
            state <= ST_IDLE;
          end
        end
        ST_ROWS: begin
          if (issue && (gy_inc == gy_end)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_draw) begin
      d_glyph <= q_head.glyph;
      d_x0    <= q_head.x0;
      d_pen   <= q_head.pen_after;
    end
    if (state == ST_SETUP) begin
      colmask <= bgr_pkg::low_bits(gx1) & ~bgr_pkg::low_bits(gx0);
      gy      <= gy0;
      gy_end  <= gy1;
    end
    if (issue) begin
      gy       <= gy_inc;
      row_py   <= oy16 + $signed({10'b0, gy});
      row_last <= (gy_inc == gy_end);
    end
  end

  always_comb begin
    oq_in.pixel_x   = px_sat;
    oq_in.pen_after = d_pen;
    if (inflight) begin
      oq_in.row_valid = 1'b1;
      oq_in.pixel_y   = row_py;
      oq_in.row_mask  = rd_data & colmask;
      oq_in.last      = row_last;
    end else begin
      oq_in.row_valid = 1'b0;
      oq_in.pixel_y   = oy16;
      oq_in.row_mask  = '0;
      oq_in.last      = 1'b1;
    end
  end

  assign oq_push = inflight | push_clip;
  assign empty = (oq_count == '0);
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      oq_count <= oq_count + {2'b0, oq_push} - {2'b0, oq_pop};
    end
  end

  assign oq_out    = oq[oq_rd];
  assign row_valid = oq_out.row_valid;
  assign pixel_x   = oq_out.pixel_x;
  assign pixel_y   = oq_out.pixel_y;
  assign row_mask  = oq_out.row_mask;
  assign pen_after = oq_out.pen_after;
  assign last      = oq_out.last;

endmodule

>>> hdl/bitmap_glyph_row_renderer_unit.sv
// Top level of the glyph row renderer: configuration registers and the front and back ends.
//
// Commands enter through a queue-style port: a command is transferred when push is high and
// full is low. Map writes and glyph row writes give no result; a draw gives one result per
// glyph row inside the vertical clip, or a single result with row_valid low when the glyph
// lies wholly outside the clip. Results leave through a queue-style port: the oldest result
// is on the result ports while empty is low and is transferred when pop is high.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register per cycle;
// the user must write it only while no draw is in progress; the block does not enforce it.
// Writes go at one a cycle while full is low. A draw passes the front end input register,
// the work queue, the back end setup state and the glyph row store read; its visible rows
// go at one a cycle while the result queue has room, set by the single read port of the
// glyph row store. Reset clears the pen and the queues, and starts a clearing pass over
// the 65536-entry code map: full stays high while it runs, configuration writes are still
// taken. When the receiver stops popping, the four-entry result queue fills, the row
// sequencer holds, the work queue fills and full rises; nothing is dropped.
module bitmap_glyph_row_renderer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic [20:0]        code_point,
  input  logic [11:0]        glyph_index,
  input  logic               map_valid,
  input  logic [4:0]         glyph_row,
  input  logic [31:0]        row_bits,
  input  logic               last_char,
  output logic               empty,
  input  logic               pop,
  output logic               row_valid,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic [31:0]        row_mask,
  output logic [15:0]        pen_after,
  output logic               last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  bgr_pkg::cfg_t      cfg;
  bgr_pkg::q_status_t q_status;
  bgr_pkg::q_entry_t  q_wr_data;
  bgr_pkg::q_entry_t  q_head;
  logic               q_push;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.clip_left    <= 12'd0;
      cfg.clip_right   <= 12'd4095;
      cfg.clip_top     <= 12'd0;
      cfg.clip_bottom  <= 12'd4095;
      cfg.glyph_width  <= 6'd6;
      cfg.glyph_height <= 6'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgr_pkg::REG_ORIGIN_X:     cfg.origin_x     <= cfg_data;
        bgr_pkg::REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data;
        bgr_pkg::REG_CLIP_LEFT:    cfg.clip_left    <= cfg_data[11:0];
        bgr_pkg::REG_CLIP_RIGHT:   cfg.clip_right   <= cfg_data[11:0];
        bgr_pkg::REG_CLIP_TOP:     cfg.clip_top     <= cfg_data[11:0];
        bgr_pkg::REG_CLIP_BOTTOM:  cfg.clip_bottom  <= cfg_data[11:0];
        bgr_pkg::REG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[5:0];
        bgr_pkg::REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  bgr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .code_point  (code_point),
    .glyph_index (glyph_index),
    .map_valid   (map_valid),
    .glyph_row   (glyph_row),
    .row_bits    (row_bits),
    .last_char   (last_char),
    .cfg         (cfg),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  bgr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_head),
    .status  (q_status)
  );

  bgr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_status.empty),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .pop       (pop),
    .empty     (empty),
    .row_valid (row_valid),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .row_mask  (row_mask),
    .pen_after (pen_after),
    .last      (last)
  );

endmodule

>>> tb/testbench.sv
// Testbench for the glyph row renderer: directed and random command streams checked by a scoreboard.
`timescale 1ns / 100ps

module testbench;
  import bgr_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int ROWS_PER_GLYPH = MAX_GLYPH_HEIGHT;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int PEN_RUN_DRAWS = 2080;

  typedef struct {
    logic [1:0]  command;
    logic [20:0] code_point;
    logic [11:0] glyph_index;
    logic        map_valid;
    logic [4:0]  glyph_row;
    logic [31:0] row_bits;
    logic        last_char;
  } glyph_cmd_t;

  class glyph_row_tracker;
    logic [31:0] glyph_bits [GLYPH_WORDS];
    bit          bits_known [GLYPH_WORDS];
    logic [12:0] char_map [CODE_SPACE];
    int          pen;
    int          origin_x, origin_y;
    int          clip_left, clip_right, clip_top, clip_bottom;
    int          width_reg, height_reg;
    r_entry_t    due_rows [$];
    int          errors;

    function new();
      foreach (char_map[i]) char_map[i] = '0;
      pen = 0;
      origin_x = 0;
      origin_y = 0;
      clip_left = 0;
      clip_right = 4095;
      clip_top = 0;
      clip_bottom = 4095;
      width_reg = 6;
      height_reg = 12;
      errors = 0;
    endfunction

    function logic [31:0] span_bits(int n);
      if (n <= 0) return 32'h0;
      if (n >= 32) return 32'hFFFF_FFFF;
      return (32'h1 << n) - 32'h1;
    endfunction

    function int clamp_span(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function logic signed [15:0] sat16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    function void set_reg(logic [2:0] idx, logic [14:0] val);
      case (idx)
        REG_ORIGIN_X:     origin_x = int'($signed(val));
        REG_ORIGIN_Y:     origin_y = int'($signed(val));
        REG_CLIP_LEFT:    clip_left = int'(val[11:0]);
        REG_CLIP_RIGHT:   clip_right = int'(val[11:0]);
        REG_CLIP_TOP:     clip_top = int'(val[11:0]);
        REG_CLIP_BOTTOM:  clip_bottom = int'(val[11:0]);
        REG_GLYPH_WIDTH:  width_reg = int'(val[5:0]);
        REG_GLYPH_HEIGHT: height_reg = int'(val[5:0]);
        default: ;
      endcase
    endfunction

    function int glyph_w();
      return (width_reg > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : width_reg;
    endfunction

    function int glyph_h();
      return (height_reg > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : height_reg;
    endfunction

    function int glyph_for(logic [20:0] cp);
      if (cp < CODE_SPACE && char_map[cp[15:0]][12]) return int'(char_map[cp[15:0]][11:0]);
      if (char_map[FALLBACK_CP][12]) return int'(char_map[FALLBACK_CP][11:0]);
      return 0;
    endfunction

    function void render_char(logic [20:0] cp, logic lastc);
      int g, gw, gh, adv, total, x0, gy0, gy1, gx0, gx1;
      bit mark;
      logic [31:0] cols;
      r_entry_t row;
      g = glyph_for(cp);
      gw = glyph_w();
      gh = glyph_h();
      mark = (cp >= COMB_A_LO && cp <= COMB_A_HI) || (cp >= COMB_B_LO && cp <= COMB_B_HI);
      adv = (lastc || !mark) ? gw : 0;
      total = pen + adv;
      if (total > 65535) total = 65535;
      x0 = origin_x + pen;
      gy0 = clamp_span(clip_top - origin_y, gh);
      gy1 = clamp_span(clip_bottom - origin_y, gh);
      gx0 = clamp_span(clip_left - x0, gw);
      gx1 = clamp_span(clip_right - x0, gw);
      pen = lastc ? 0 : total;
      row.pixel_x = sat16(x0);
      row.pen_after = 16'(total);
      if (gy0 >= gy1 || gx0 >= gx1) begin
        row.row_valid = 1'b0;
        row.pixel_y = 16'(origin_y);
        row.row_mask = '0;
        row.last = 1'b1;
        due_rows.push_back(row);
        return;
      end
      cols = span_bits(gx1) & ~span_bits(gx0);
      for (int gy = gy0; gy < gy1; gy++) begin
        row.row_valid = 1'b1;
        row.pixel_y = 16'(origin_y + gy);
        row.row_mask = glyph_bits[g * ROWS_PER_GLYPH + gy] & cols;
        row.last = (gy + 1 == gy1);
        due_rows.push_back(row);
      end
    endfunction

    function void note_item(glyph_cmd_t it);
      case (it.command)
        CMD_MAP: begin
          if (it.code_point < CODE_SPACE)
            char_map[it.code_point[15:0]] = it.map_valid ? {1'b1, it.glyph_index} : 13'h0;
        end
        CMD_ROW: begin
          glyph_bits[{it.glyph_index, it.glyph_row}] = it.row_bits;
          bits_known[{it.glyph_index, it.glyph_row}] = 1'b1;
        end
        CMD_DRAW: render_char(it.code_point, it.last_char);
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] seen);
      if (seen !== want) begin
        $error("%s expected %0d actual %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(r_entry_t got);
      r_entry_t want;
      if (due_rows.size() == 0) begin
        $error("result transferred with no row expected");
        errors++;
        return;
      end
      want = due_rows.pop_front();
      compare_field("row_valid", want.row_valid, got.row_valid);
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("row_mask", want.row_mask, got.row_mask);
      compare_field("pen_after", want.pen_after, got.pen_after);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         command = '0;
  logic [20:0]        code_point = '0;
  logic [11:0]        glyph_index = '0;
  logic               map_valid = 1'b0;
  logic [4:0]         glyph_row = '0;
  logic [31:0]        row_bits = '0;
  logic               last_char = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic               row_valid;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [31:0]        row_mask;
  logic [15:0]        pen_after;
  logic               last;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [14:0]        cfg_data = '0;

  glyph_row_tracker tracker;
  bit               tx_idle;
  bit               rx_idle;
  bit               hold_req;
  int unsigned      mapped_cps [$];

  bitmap_glyph_row_renderer_unit dut (.*);

  always #5 clk = ~clk;

  function automatic glyph_cmd_t noise_fields();
    glyph_cmd_t it;
    it.command = 2'($urandom_range(0, 3));
    it.code_point = 21'($urandom_range(0, 1114111));
    it.glyph_index = 12'($urandom);
    it.map_valid = 1'($urandom);
    it.glyph_row = 5'($urandom);
    it.row_bits = $urandom;
    it.last_char = 1'($urandom);
    return it;
  endfunction

  function automatic int unsigned pick_glyph();
    int unsigned r;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 4095);
    r = $urandom_range(0, 8);
    return (r == 8) ? 4095 : r;
  endfunction

  function automatic int unsigned pick_code();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45 && mapped_cps.size() != 0)
      return mapped_cps[$urandom_range(0, mapped_cps.size() - 1)];
    if (sel < 55) return $urandom_range(COMB_A_LO, COMB_A_HI);
    if (sel < 62) return $urandom_range(COMB_B_LO, COMB_B_HI);
    if (sel < 72) return $urandom_range(0, 255);
    if (sel < 82) return $urandom_range(0, 65535);
    if (sel < 92) return $urandom_range(65536, 1114111);
    return FALLBACK_CP;
  endfunction

  function automatic int pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(33, 63);
    return $urandom_range(1, 32);
  endfunction

  task automatic send_item(glyph_cmd_t it);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push <= 1'b1;
    command <= it.command;
    code_point <= it.code_point;
    glyph_index <= it.glyph_index;
    map_valid <= it.map_valid;
    glyph_row <= it.glyph_row;
    row_bits <= it.row_bits;
    last_char <= it.last_char;
    do @(posedge clk); while (full !== 1'b0);
    tracker.note_item(it);
  endtask

  task automatic send_map(int unsigned cp, int unsigned gi, bit mv);
    glyph_cmd_t it;
    it = noise_fields();
    it.command = CMD_MAP;
    it.code_point = 21'(cp);
    it.glyph_index = 12'(gi);
    it.map_valid = mv;
    send_item(it);
    if (mv && cp < CODE_SPACE) mapped_cps.push_back(cp);
  endtask

  task automatic send_row(int unsigned gi, int unsigned r, logic [31:0] bits);
    glyph_cmd_t it;
    it = noise_fields();
    it.command = CMD_ROW;
    it.glyph_index = 12'(gi);
    it.glyph_row = 5'(r);
    it.row_bits = bits;
    send_item(it);
  endtask

  // fill any glyph row the draw could read that has not been loaded yet
  task automatic send_draw(int unsigned cp, bit lastc);
    glyph_cmd_t it;
    int g;
    int gh;
    g = tracker.glyph_for(21'(cp));
    gh = tracker.glyph_h();
    for (int r = 0; r < gh; r++)
      if (!tracker.bits_known[g * ROWS_PER_GLYPH + r]) send_row(g, r, $urandom);
    it = noise_fields();
    it.command = CMD_DRAW;
    it.code_point = 21'(cp);
    it.last_char = lastc;
    send_item(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic write_config(int ox, int oy, int cl, int cr, int ct, int cb, int w, int h);
    write_reg(REG_ORIGIN_X, 15'(ox));
    write_reg(REG_ORIGIN_Y, 15'(oy));
    write_reg(REG_CLIP_LEFT, 15'(cl));
    write_reg(REG_CLIP_RIGHT, 15'(cr));
    write_reg(REG_CLIP_TOP, 15'(ct));
    write_reg(REG_CLIP_BOTTOM, 15'(cb));
    write_reg(REG_GLYPH_WIDTH, 15'(w));
    write_reg(REG_GLYPH_HEIGHT, 15'(h));
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int ox, oy, cl, ct;
    ox = int'($urandom_range(0, 300)) - 150;
    oy = int'($urandom_range(0, 300)) - 150;
    if ($urandom_range(0, 4) == 0) ox = int'($urandom_range(0, 32767)) - 16384;
    if ($urandom_range(0, 4) == 0) oy = int'($urandom_range(0, 32767)) - 16384;
    cl = $urandom_range(0, 120);
    ct = $urandom_range(0, 120);
    write_config(ox, oy, cl, cl + int'($urandom_range(0, 160)), ct, ct + int'($urandom_range(0, 160)),
                 pick_size(), pick_size());
  endtask

  task automatic drain();
    push <= 1'b0;
    while (tracker.due_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int done;
    int unsigned sel;
    int len;
    int unsigned cp;
    bit broken;
    glyph_cmd_t it;
    done = 0;
    while (done < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        case ($urandom_range(0, 5))
          0: cp = FALLBACK_CP;
          1: cp = $urandom_range(COMB_A_LO, COMB_A_HI);
          2: cp = $urandom_range(0, 255);
          5: cp = $urandom_range(65536, 1114111);
          default: cp = $urandom_range(0, 65535);
        endcase
        send_map(cp, pick_glyph(), $urandom_range(0, 9) != 0);
        if (cp < CODE_SPACE) done++;
      end else if (sel < 25) begin
        send_row(pick_glyph(), $urandom_range(0, 31), $urandom);
        done++;
      end else if (sel < 30) begin
        it = noise_fields();
        it.command = CMD_IGNORED;
        send_item(it);
      end else begin
        len = $urandom_range(1, 5);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) send_draw(pick_code(), (k == len - 1) && !broken);
        done += len;
      end
    end
  endtask

  initial begin
    r_entry_t seen;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && empty === 1'b0) begin
        seen = {row_valid, pixel_x, pixel_y, row_mask, pen_after, last};
        tracker.check_result(seen);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pop <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    glyph_cmd_t it;
    tracker = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_map('h41, 1, 1'b1);
    send_draw('h42, 1'b0);
    send_draw('h41, 1'b0);
    send_map(FALLBACK_CP, 4095, 1'b1);
    send_row(4095, 0, 32'h0);
    send_row(4095, 31, 32'hFFFF_FFFF);
    send_draw('h10FFFF, 1'b0);
    send_draw('h10000, 1'b0);
    send_draw(COMB_A_LO, 1'b0);
    send_draw(COMB_A_HI, 1'b0);
    send_draw(COMB_B_LO, 1'b0);
    send_draw(COMB_B_HI, 1'b1);
    send_map('h10000, 3, 1'b1);
    send_map('h41, 0, 1'b0);
    send_draw('h41, 1'b1);
    it = noise_fields();
    it.command = CMD_IGNORED;
    it.code_point = '1;
    it.glyph_index = '1;
    it.row_bits = '1;
    send_item(it);
    send_map(FALLBACK_CP, 0, 1'b0);
    send_draw('hFFFF, 1'b1);
    send_draw(0, 1'b1);
    drain();

    write_config(-16384, -16384, 0, 4095, 0, 4095, 63, 63);
    random_phase(15);
    drain();
    write_config(100, 200, 103, 150, 205, 220, 32, 32);
    hold_req = 1'b1;
    random_phase(30);
    drain();
    write_config(0, 0, 0, 4095, 0, 4095, 0, 0);
    random_phase(10);
    drain();
    write_config(4094, 4094, 0, 4095, 0, 4095, 32, 32);
    random_phase(10);
    drain();
    write_config(4090, 4090, 4095, 4095, 4095, 4095, 8, 8);
    random_phase(6);
    drain();

    // drive the pen into saturation with the glyph pushed past the screen x range
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_config(16383, 0, 0, 4095, 0, 0, 63, 1);
    for (int i = 0; i < PEN_RUN_DRAWS; i++) send_draw($urandom_range(0, 1114111), 1'b0);
    send_draw('h41, 1'b1);
    drain();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int p = 0; p < 5; p++) begin
      if (p >= 3) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      random_config();
      random_phase(22);
      drain();
    end

    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
